FILE: hw/rtl/ssc_pkg.sv
package ssc_pkg;

  localparam int SQ_STEPS = 33;
  localparam int DV_STEPS = 32;
  localparam int PIPE_LEN = 75;

  typedef struct packed {
    logic signed [31:0] bx;
    logic signed [31:0] cx;
    logic signed [31:0] fx;
    logic               is_line;
    logic               up_line;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic               neg;
    logic signed [34:0] d;
    logic signed [32:0] e;
    logic signed [32:0] ln;
    logic signed [32:0] ld;
    logic [65:0]        rad;
    logic [32:0]        root;
    logic [33:0]        rem;
  } sq_t;

  typedef struct packed {
    logic        ok;
    logic        one;
    logic [34:0] r;
    logic [33:0] ud;
    logic [31:0] q;
  } dv_lane_t;

  typedef struct packed {
    side_t               side;
    dv_lane_t [1:0]      lane;
  } dv_t;

  typedef struct packed {
    logic        ok;
    logic [32:0] t;
    logic        neg0;
    logic        neg1;
    logic [31:0] mag0;
    logic [31:0] mag1;
    logic [64:0] prod0;
    logic [64:0] prod1;
    logic [31:0] p0;
    logic [31:0] p1;
    logic [31:0] x;
  } lp_lane_t;

  typedef struct packed {
    side_t           side;
    lp_lane_t [1:0]  lane;
  } lp_t;

endpackage

FILE: hw/rtl/scanline_segment_crossing_top.sv
// Pipeline: 75 internal stages plus output register.
// Throughput: one segment per cycle; the whole pipeline advances when the output
// register is empty or being taken.
// Sqrt takes 33 stages (one root bit each), the t divider 32 stages (one quotient bit each).
// Reset (rst, synchronous) clears all stage valid bits and the output valid.
module scanline_segment_crossing_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] begin_x,
  input  logic signed [31:0] begin_y,
  input  logic signed [31:0] ctrl_x,
  input  logic signed [31:0] ctrl_y,
  input  logic signed [31:0] finish_x,
  input  logic signed [31:0] finish_y,
  input  logic               is_line,
  input  logic signed [31:0] scan_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         crossing_count,
  output logic signed [31:0] first_x,
  output logic               first_up,
  output logic signed [31:0] second_x,
  output logic               second_up
);

  function automatic ssc_pkg::sq_t sq_step(input ssc_pkg::sq_t s);
    ssc_pkg::sq_t o;
    logic [35:0] rem2;
    logic [35:0] trial;
    o = s;
    rem2 = {s.rem, s.rad[65:64]};
    trial = {1'b0, s.root, 2'b01};
    if (rem2 >= trial) begin
      o.rem = 34'(rem2 - trial);
      o.root = {s.root[31:0], 1'b1};
    end else begin
      o.rem = rem2[33:0];
      o.root = {s.root[31:0], 1'b0};
    end
    o.rad = {s.rad[63:0], 2'b00};
    return o;
  endfunction

  function automatic ssc_pkg::dv_lane_t dv_init(input logic signed [34:0] n,
                                                input logic signed [34:0] dd,
                                                input logic allow);
    ssc_pkg::dv_lane_t o;
    logic signed [34:0] nn;
    logic signed [34:0] dn;
    dn = dd[34] ? -dd : dd;
    nn = dd[34] ? -n : n;
    o.ok = allow && (dd != '0) && !nn[34] && (nn <= dn);
    o.one = (nn == dn);
    o.r = {1'b0, nn[33:0]};
    o.ud = dn[33:0];
    o.q = '0;
    return o;
  endfunction

  function automatic ssc_pkg::dv_lane_t dv_step(input ssc_pkg::dv_lane_t l);
    ssc_pkg::dv_lane_t o;
    logic [34:0] r2;
    logic        ge;
    o = l;
    r2 = {l.r[33:0], 1'b0};
    ge = (r2 >= {1'b0, l.ud});
    o.r = ge ? (r2 - {1'b0, l.ud}) : r2;
    o.q = {l.q[30:0], ge};
    return o;
  endfunction

  // {sign, magnitude} of b - a
  function automatic logic [32:0] mag_of(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] df;
    df = {b[31], b} - {a[31], a};
    return {df[32], df[32] ? (~df[31:0] + 32'd1) : df[31:0]};
  endfunction

  // a +/- round(prod / 2^32)
  function automatic logic [31:0] fin(input logic [31:0] a, input logic [64:0] prod,
                                      input logic neg);
    logic [64:0] rnd;
    logic [31:0] off;
    rnd = prod + 65'h0_8000_0000;
    off = rnd[63:32];
    return neg ? (a - off) : (a + off);
  endfunction

  logic                            en;
  logic [ssc_pkg::PIPE_LEN-1:0]    vld;

  ssc_pkg::side_t     a_side;
  logic [31:0]        a_ua;
  logic [31:0]        a_ub;
  logic [31:0]        a_uc;
  logic               a_same;
  logic signed [34:0] a_d;
  logic signed [32:0] a_e;
  logic signed [32:0] a_ln;
  logic signed [32:0] a_ld;

  ssc_pkg::side_t     b_side;
  logic [63:0]        b_bsq;
  logic [63:0]        b_ac;
  logic               b_same;
  logic signed [34:0] b_d;
  logic signed [32:0] b_e;
  logic signed [32:0] b_ln;
  logic signed [32:0] b_ld;

  ssc_pkg::sq_t sq [0:ssc_pkg::SQ_STEPS];
  ssc_pkg::dv_t dv [0:ssc_pkg::DV_STEPS];
  ssc_pkg::lp_t lp [1:6];

  logic signed [32:0] ap_w;
  logic signed [32:0] bp_w;
  logic signed [32:0] cp_w;
  ssc_pkg::sq_t       sq0_next;
  ssc_pkg::dv_t       dv0_next;
  ssc_pkg::lp_t       lp1_next;
  ssc_pkg::lp_t       lp2_next;
  ssc_pkg::lp_t       lp3_next;
  ssc_pkg::lp_t       lp4_next;
  ssc_pkg::lp_t       lp5_next;
  ssc_pkg::lp_t       lp6_next;
  logic [1:0]         count_next;
  logic [31:0]        first_x_next;
  logic               first_up_next;
  logic [31:0]        second_x_next;
  logic               second_up_next;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  assign ap_w = {begin_y[31], begin_y} - {scan_y[31], scan_y};
  assign bp_w = {ctrl_y[31], ctrl_y} - {scan_y[31], scan_y};
  assign cp_w = {finish_y[31], finish_y} - {scan_y[31], scan_y};

  always_comb begin
    logic signed [34:0] s35;
    logic signed [34:0] e35;
    sq0_next.side = b_side;
    sq0_next.d = b_d;
    sq0_next.e = b_e;
    sq0_next.ln = b_ln;
    sq0_next.ld = b_ld;
    sq0_next.root = '0;
    sq0_next.rem = '0;
    sq0_next.neg = 1'b0;
    if (b_same && (b_ac != '0)) begin
      sq0_next.neg = (b_bsq < b_ac);
      sq0_next.rad = {2'b00, b_bsq - b_ac};
    end else begin
      sq0_next.rad = {1'b0, {1'b0, b_bsq} + {1'b0, b_ac}};
    end

    s35 = {2'b00, sq[ssc_pkg::SQ_STEPS].root};
    e35 = {{2{sq[ssc_pkg::SQ_STEPS].e[32]}}, sq[ssc_pkg::SQ_STEPS].e};
    dv0_next.side = sq[ssc_pkg::SQ_STEPS].side;
    if (sq[ssc_pkg::SQ_STEPS].side.is_line) begin
      dv0_next.lane[0] = dv_init({{2{sq[ssc_pkg::SQ_STEPS].ln[32]}}, sq[ssc_pkg::SQ_STEPS].ln},
                                 {{2{sq[ssc_pkg::SQ_STEPS].ld[32]}}, sq[ssc_pkg::SQ_STEPS].ld},
                                 1'b1);
      dv0_next.lane[1] = dv_init(e35 - s35, sq[ssc_pkg::SQ_STEPS].d, 1'b0);
    end else begin
      dv0_next.lane[0] = dv_init(s35 + e35, sq[ssc_pkg::SQ_STEPS].d,
                                 !sq[ssc_pkg::SQ_STEPS].neg);
      dv0_next.lane[1] = dv_init(e35 - s35, sq[ssc_pkg::SQ_STEPS].d,
                                 !sq[ssc_pkg::SQ_STEPS].neg);
    end
  end

  // interpolation stages
  always_comb begin
    lp1_next = '0;
    lp1_next.side = dv[ssc_pkg::DV_STEPS].side;
    for (int k = 0; k < 2; k++) begin
      lp1_next.lane[k].ok = dv[ssc_pkg::DV_STEPS].lane[k].ok;
      lp1_next.lane[k].t = dv[ssc_pkg::DV_STEPS].lane[k].one ? {1'b1, 32'd0}
                                                             : {1'b0, dv[ssc_pkg::DV_STEPS].lane[k].q};
      {lp1_next.lane[k].neg0, lp1_next.lane[k].mag0} =
        mag_of(dv[ssc_pkg::DV_STEPS].side.bx,
               dv[ssc_pkg::DV_STEPS].side.is_line ? dv[ssc_pkg::DV_STEPS].side.fx
                                                   : dv[ssc_pkg::DV_STEPS].side.cx);
      {lp1_next.lane[k].neg1, lp1_next.lane[k].mag1} =
        mag_of(dv[ssc_pkg::DV_STEPS].side.cx, dv[ssc_pkg::DV_STEPS].side.fx);
    end

    lp2_next = lp[1];
    for (int k = 0; k < 2; k++) begin
      lp2_next.lane[k].prod0 = 65'(lp[1].lane[k].mag0) * 65'(lp[1].lane[k].t);
      lp2_next.lane[k].prod1 = 65'(lp[1].lane[k].mag1) * 65'(lp[1].lane[k].t);
    end

    lp3_next = lp[2];
    for (int k = 0; k < 2; k++) begin
      lp3_next.lane[k].p0 = fin(lp[2].side.bx, lp[2].lane[k].prod0, lp[2].lane[k].neg0);
      lp3_next.lane[k].p1 = fin(lp[2].side.cx, lp[2].lane[k].prod1, lp[2].lane[k].neg1);
    end

    lp4_next = lp[3];
    for (int k = 0; k < 2; k++) begin
      {lp4_next.lane[k].neg0, lp4_next.lane[k].mag0} =
        mag_of(lp[3].lane[k].p0, lp[3].lane[k].p1);
    end

    lp5_next = lp[4];
    for (int k = 0; k < 2; k++) begin
      lp5_next.lane[k].prod0 = 65'(lp[4].lane[k].mag0) * 65'(lp[4].lane[k].t);
    end

    lp6_next = lp[5];
    for (int k = 0; k < 2; k++) begin
      lp6_next.lane[k].x = lp[5].side.is_line ? lp[5].lane[k].p0
                         : fin(lp[5].lane[k].p0, lp[5].lane[k].prod0, lp[5].lane[k].neg0);
    end
  end

  // pack crossings in root order
  always_comb begin
    count_next = {1'b0, lp[6].lane[0].ok} + {1'b0, lp[6].lane[1].ok};
    first_x_next = '0;
    first_up_next = 1'b0;
    second_x_next = '0;
    second_up_next = 1'b0;
    if (lp[6].lane[0].ok) begin
      first_x_next = lp[6].lane[0].x;
      first_up_next = lp[6].side.is_line ? lp[6].side.up_line : 1'b1;
      if (lp[6].lane[1].ok) begin
        second_x_next = lp[6].lane[1].x;
      end
    end else if (lp[6].lane[1].ok) begin
      first_x_next = lp[6].lane[1].x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[ssc_pkg::PIPE_LEN-2:0], in_valid};
      out_valid <= vld[ssc_pkg::PIPE_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side.bx <= begin_x;
      a_side.cx <= ctrl_x;
      a_side.fx <= finish_x;
      a_side.is_line <= is_line;
      a_side.up_line <= (finish_y > begin_y);
      a_ua <= ap_w[32] ? (~ap_w[31:0] + 32'd1) : ap_w[31:0];
      a_ub <= bp_w[32] ? (~bp_w[31:0] + 32'd1) : bp_w[31:0];
      a_uc <= cp_w[32] ? (~cp_w[31:0] + 32'd1) : cp_w[31:0];
      a_same <= (ap_w[32] == cp_w[32]);
      a_d <= {{3{begin_y[31]}}, begin_y} - {{2{ctrl_y[31]}}, ctrl_y, 1'b0}
             + {{3{finish_y[31]}}, finish_y};
      a_e <= {begin_y[31], begin_y} - {ctrl_y[31], ctrl_y};
      a_ln <= {scan_y[31], scan_y} - {begin_y[31], begin_y};
      a_ld <= {finish_y[31], finish_y} - {begin_y[31], begin_y};

      b_side <= a_side;
      b_bsq <= 64'(a_ub) * 64'(a_ub);
      b_ac <= 64'(a_ua) * 64'(a_uc);
      b_same <= a_same;
      b_d <= a_d;
      b_e <= a_e;
      b_ln <= a_ln;
      b_ld <= a_ld;

      sq[0] <= sq0_next;
      for (int i = 1; i <= ssc_pkg::SQ_STEPS; i++) begin
        sq[i] <= sq_step(sq[i-1]);
      end

      dv[0] <= dv0_next;
      for (int i = 1; i <= ssc_pkg::DV_STEPS; i++) begin
        dv[i].side <= dv[i-1].side;
        dv[i].lane[0] <= dv_step(dv[i-1].lane[0]);
        dv[i].lane[1] <= dv_step(dv[i-1].lane[1]);
      end

      lp[1] <= lp1_next;
      lp[2] <= lp2_next;
      lp[3] <= lp3_next;
      lp[4] <= lp4_next;
      lp[5] <= lp5_next;
      lp[6] <= lp6_next;

      crossing_count <= count_next;
      first_x <= first_x_next;
      first_up <= first_up_next;
      second_x <= second_x_next;
      second_up <= second_up_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> crossing_count != 2'd3)
    else $error("crossing count out of range");

  a_second_unused: assert property (@(posedge clk) disable iff (rst)
    (out_valid && crossing_count != 2'd2) |-> (second_x == '0 && !second_up))
    else $error("unused second crossing not zero");

  a_first_unused: assert property (@(posedge clk) disable iff (rst)
    (out_valid && crossing_count == 2'd0) |-> (first_x == '0 && !first_up))
    else $error("unused first crossing not zero");

  a_line_one_root: assert property (@(posedge clk) disable iff (rst)
    (vld[ssc_pkg::PIPE_LEN-1] && lp[6].side.is_line) |-> !lp[6].lane[1].ok)
    else $error("line produced a second root");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (en && vld[ssc_pkg::PIPE_LEN-1]) |=> out_valid)
    else $error("finished item not loaded into output register");
`endif

endmodule
